>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication in the same cycle, on aclk, masked during reset.
`define ASSERT_IMPLIES(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error(msg);

// Check an implication in the next cycle, on aclk, masked during reset.
`define ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error(msg);

`endif

>>> rtl/rcsc_pkg.sv
`default_nettype none

package rcsc_pkg;

    localparam logic [1:0] MODE_SETPOINT = 2'd0;
    localparam logic [1:0] MODE_THRUST   = 2'd1;
    localparam logic [1:0] MODE_TOGGLE   = 2'd2;

    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_TARGET    = 3'd1;
    localparam logic [2:0] REG_TOLERANCE = 3'd2;
    localparam logic [2:0] REG_CENTRE    = 3'd3;
    localparam logic [2:0] REG_TOP       = 3'd4;
    localparam logic [2:0] REG_DEADBAND  = 3'd5;
    localparam logic [2:0] REG_GAIN      = 3'd6;
    localparam logic [2:0] REG_BOUND     = 3'd7;

    localparam logic [1:0]  RST_MODE      = MODE_SETPOINT;
    localparam logic [15:0] RST_TARGET    = 16'd550;
    localparam logic [15:0] RST_TOLERANCE = 16'd10;
    localparam logic [13:0] RST_CENTRE    = 14'd750;
    localparam logic [13:0] RST_TOP       = 14'd1000;
    localparam logic [13:0] RST_DEADBAND  = 14'd20;
    localparam logic [15:0] RST_GAIN      = 16'd256;
    localparam logic [14:0] RST_BOUND     = 15'd32767;

    localparam int          HIST_DEPTH     = 6;
    localparam int          TAP_LAST       = HIST_DEPTH;
    localparam logic [11:0] FILTER_DIVISOR = 12'd2520;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] freq_target;
        logic [15:0] freq_tolerance;
        logic [13:0] duty_centre;
        logic [13:0] duty_top;
        logic [13:0] duty_deadband;
        logic [15:0] gain;
        logic [14:0] output_bound;
    } rcsc_cfg_t;

    function automatic logic [9:0] filter_weight(input logic [2:0] tap);
        logic [9:0] w;
        case (tap)
            3'd0:    w = 10'd630;
            3'd1:    w = 10'd504;
            3'd2:    w = 10'd420;
            3'd3:    w = 10'd360;
            3'd4:    w = 10'd315;
            3'd5:    w = 10'd280;
            3'd6:    w = 10'd11;
            default: w = 10'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rc_stick_channel_conditioner.sv
// Setpoint and thrust modes raise m_tvalid once the request has passed the filter steps
// (7 multiply-accumulate taps, 1 reciprocal multiply for the divide by 2520, scale, clamp);
// toggle mode skips them and raises it once the finish step has registered the result.
// In every mode no new request is taken until the last result has been taken; the single
// shared multiplier serves all filter steps, and a held result stalls input.
// Reset: synchronous active-low aresetn clears history, sequencer and configuration registers to defaults.
`default_nettype none

module rc_stick_channel_conditioner
    import rcsc_pkg::*;
#(
    parameter int DUTY_WIDTH = 14
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      s_tvalid,
    output logic                                           s_tready,
    // freq [15:0], duty [16 +: DUTY_WIDTH], zero padding above
    input  wire logic [((16 + DUTY_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                           m_tvalid,
    input  wire logic                                      m_tready,
    // value [15:0], smoothed_duty [29:16] (raw duty in toggle mode), zero padding [31:30]
    output logic      [31:0]                               m_tdata,
    // signal_ok [0]
    output logic      [0:0]                                m_tuser,
    input  wire logic                                      psel,
    input  wire logic                                      penable,
    input  wire logic                                      pwrite,
    input  wire logic [4:0]                                paddr,
    input  wire logic [31:0]                               pwdata,
    output logic      [31:0]                               prdata,
    output logic                                           pready
);

    localparam int ACC_W = DUTY_WIDTH + 12;
    localparam int EXT_W = ((DUTY_WIDTH > 14) ? DUTY_WIDTH : 14) + 1;
    localparam int MUL_W = 16 + EXT_W;
    localparam int MAG_W = MUL_W - 8;
    localparam int MA_W = ACC_W + 1;
    localparam int PROD_W = MA_W + ACC_W;
    localparam int RECIP_SHIFT = ACC_W + 12;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(FILTER_DIVISOR) - 64'd1) / 64'(FILTER_DIVISOR);
    localparam logic [MA_W-1:0] RECIP = RECIP_FULL[MA_W-1:0];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DIV,
        ST_SCALE,
        ST_FINISH,
        ST_OUT
    } state_t;

    rcsc_cfg_t cfg;

    rcsc_cfg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    state_t                  state_reg,  state_next;
    logic [2:0]              tap_reg,    tap_next;
    logic [DUTY_WIDTH-1:0]   raw_reg,    raw_next;
    logic                    ok_reg,     ok_next;
    logic [ACC_W-1:0]        acc_reg,    acc_next;
    logic [DUTY_WIDTH-1:0]   quo_reg,    quo_next;
    logic [DUTY_WIDTH-1:0]   hist_reg    [HIST_DEPTH];
    logic [DUTY_WIDTH-1:0]   hist_next   [HIST_DEPTH];
    logic [MUL_W-1:0]        prod_reg,   prod_next;
    logic                    neg_reg,    neg_next;
    logic                    zero_reg,   zero_next;
    logic                    valid_reg,  valid_next;
    logic [15:0]             value_reg,  value_next;
    logic [13:0]             shown_reg,  shown_next;

    logic [15:0]             s_freq;
    logic [DUTY_WIDTH-1:0]   s_duty;
    logic [16:0]             win_hi;
    logic [16:0]             win_lo;
    logic                    win_ok;
    logic                    is_toggle;
    logic [2:0]              hist_idx;
    logic [DUTY_WIDTH-1:0]   mac_opnd;
    logic [MA_W-1:0]         mul_a;
    logic [ACC_W-1:0]        mul_b;
    logic [PROD_W-1:0]       mul_p;
    logic [EXT_W-1:0]        f_ext;
    logic [EXT_W-1:0]        c_ext;
    logic [EXT_W-1:0]        t_ext;
    logic [EXT_W-1:0]        db_ext;
    logic [EXT_W-1:0]        span;
    logic                    dist_neg;
    logic                    dist_zero;
    logic [MAG_W-1:0]        mag_raw;
    logic [14:0]             mag;
    logic [DUTY_WIDTH-1:0]   shown_src;
    logic [31:0]             shown_wide;

    assign s_freq    = s_tdata[15:0];
    assign s_duty    = s_tdata[16 +: DUTY_WIDTH];
    assign win_hi    = {1'b0, cfg.freq_target} + {1'b0, cfg.freq_tolerance};
    assign win_lo    = {1'b0, s_freq} + {1'b0, cfg.freq_tolerance};
    assign win_ok    = ({1'b0, s_freq} < win_hi) && (win_lo > {1'b0, cfg.freq_target});
    assign is_toggle = (cfg.mode != MODE_SETPOINT) && (cfg.mode != MODE_THRUST);

    // Shared multiplier: filter taps in ST_MAC, reciprocal of 2520 in ST_DIV, gain otherwise.
    assign hist_idx = tap_reg - 3'd1;
    assign mac_opnd = (tap_reg == 3'd0) ? raw_reg : hist_reg[hist_idx];
    assign mul_a    = (state_reg == ST_MAC) ? MA_W'(filter_weight(tap_reg))
                    : (state_reg == ST_DIV) ? RECIP
                    : MA_W'(cfg.gain);
    assign mul_b    = (state_reg == ST_MAC) ? ACC_W'(mac_opnd)
                    : (state_reg == ST_DIV) ? acc_reg
                    : ACC_W'(span);
    assign mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign f_ext  = EXT_W'(quo_reg);
    assign c_ext  = EXT_W'(cfg.duty_centre);
    assign t_ext  = EXT_W'(cfg.duty_top);
    assign db_ext = EXT_W'(cfg.duty_deadband);

    always_comb begin
        span      = '0;
        dist_neg  = 1'b0;
        dist_zero = 1'b1;
        if (cfg.mode == MODE_SETPOINT) begin
            if (f_ext + db_ext <= c_ext) begin
                span      = c_ext - f_ext;
                dist_zero = 1'b0;
            end else if (f_ext >= c_ext + db_ext) begin
                span      = f_ext - c_ext;
                dist_neg  = 1'b1;
                dist_zero = 1'b0;
            end
        end else if (f_ext + db_ext <= t_ext) begin
            span      = t_ext - f_ext;
            dist_zero = 1'b0;
        end
    end

    assign mag_raw    = prod_reg[MUL_W-1:8];
    assign mag        = (mag_raw > MAG_W'(cfg.output_bound)) ? cfg.output_bound
                                                             : mag_raw[14:0];
    assign shown_src  = is_toggle ? raw_reg : quo_reg;
    assign shown_wide = 32'(shown_src);

    always_comb begin
        state_next = state_reg;
        tap_next   = tap_reg;
        raw_next   = raw_reg;
        ok_next    = ok_reg;
        acc_next   = acc_reg;
        quo_next   = quo_reg;
        hist_next  = hist_reg;
        prod_next  = prod_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        valid_next = valid_reg;
        value_next = value_reg;
        shown_next = shown_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    raw_next   = s_duty;
                    ok_next    = win_ok;
                    tap_next   = 3'd0;
                    acc_next   = '0;
                    state_next = is_toggle ? ST_FINISH : ST_MAC;
                end
            end
            ST_MAC: begin
                acc_next = acc_reg + mul_p[ACC_W-1:0];
                tap_next = tap_reg + 3'd1;
                if (tap_reg == 3'(TAP_LAST)) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                quo_next   = mul_p[RECIP_SHIFT +: DUTY_WIDTH];
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                hist_next[0] = quo_reg;
                for (int i = 1; i < HIST_DEPTH; i++) begin
                    hist_next[i] = hist_reg[i-1];
                end
                prod_next  = mul_p[MUL_W-1:0];
                neg_next   = dist_neg;
                zero_next  = dist_zero | ~ok_reg;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (is_toggle) begin
                    value_next = (ok_reg && (EXT_W'(raw_reg) > c_ext)) ? 16'd1 : 16'd0;
                end else if (zero_reg) begin
                    value_next = 16'd0;
                end else if (neg_reg) begin
                    value_next = 16'd0 - {1'b0, mag};
                end else begin
                    value_next = {1'b0, mag};
                end
                shown_next = shown_wide[13:0];
                valid_next = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    valid_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            for (int i = 0; i < HIST_DEPTH; i++) begin
                hist_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            hist_reg  <= hist_next;
        end
        tap_reg   <= tap_next;
        raw_reg   <= raw_next;
        ok_reg    <= ok_next;
        acc_reg   <= acc_next;
        quo_reg   <= quo_next;
        prod_reg  <= prod_next;
        neg_reg   <= neg_next;
        zero_reg  <= zero_next;
        value_reg <= value_next;
        shown_reg <= shown_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, shown_reg, value_reg};
    assign m_tuser  = ok_reg;

    `include "assert_macros.svh"

    `ASSERT_IMPLIES(a_one_at_a_time, m_tvalid, !s_tready, "input taken while result pending")
    `ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "ready held after request")
    `ASSERT_IMPLIES(a_zero_when_bad, m_tvalid && !m_tuser[0], m_tdata[15:0] == 16'd0,
        "nonzero value with bad frequency")
    `ASSERT_IMPLIES(a_neg_setpoint, m_tvalid && m_tdata[15], cfg.mode == MODE_SETPOINT,
        "negative value outside setpoint mode")

endmodule

`default_nettype wire

>>> rtl/rcsc_cfg_regs.sv
`default_nettype none

module rcsc_cfg_regs
    import rcsc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output rcsc_cfg_t        cfg
);

    rcsc_cfg_t  cfg_reg;
    logic [2:0] index;
    logic       wr_en;

    assign pready = 1'b1;
    assign index  = paddr[4:2];
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode           <= RST_MODE;
            cfg_reg.freq_target    <= RST_TARGET;
            cfg_reg.freq_tolerance <= RST_TOLERANCE;
            cfg_reg.duty_centre    <= RST_CENTRE;
            cfg_reg.duty_top       <= RST_TOP;
            cfg_reg.duty_deadband  <= RST_DEADBAND;
            cfg_reg.gain           <= RST_GAIN;
            cfg_reg.output_bound   <= RST_BOUND;
        end else if (wr_en) begin
            case (index)
                REG_MODE:      cfg_reg.mode           <= pwdata[1:0];
                REG_TARGET:    cfg_reg.freq_target    <= pwdata[15:0];
                REG_TOLERANCE: cfg_reg.freq_tolerance <= pwdata[15:0];
                REG_CENTRE:    cfg_reg.duty_centre    <= pwdata[13:0];
                REG_TOP:       cfg_reg.duty_top       <= pwdata[13:0];
                REG_DEADBAND:  cfg_reg.duty_deadband  <= pwdata[13:0];
                REG_GAIN:      cfg_reg.gain           <= pwdata[15:0];
                REG_BOUND:     cfg_reg.output_bound   <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (index)
            REG_MODE:      prdata = 32'(cfg_reg.mode);
            REG_TARGET:    prdata = 32'(cfg_reg.freq_target);
            REG_TOLERANCE: prdata = 32'(cfg_reg.freq_tolerance);
            REG_CENTRE:    prdata = 32'(cfg_reg.duty_centre);
            REG_TOP:       prdata = 32'(cfg_reg.duty_top);
            REG_DEADBAND:  prdata = 32'(cfg_reg.duty_deadband);
            REG_GAIN:      prdata = 32'(cfg_reg.gain);
            REG_BOUND:     prdata = 32'(cfg_reg.output_bound);
            default:       prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire
